### hdl/mshb_pkg.sv
// ----------------------------------------------------------------------------
// mshb_pkg
// Shared types and constants of the quadratic M-spline hazard basis core.
// ----------------------------------------------------------------------------
`default_nettype none

package mshb_pkg;

   localparam int TimeW    = 16;
   localparam int CoefW    = 16;
   localparam int BasisW   = 32;
   localparam int HazW     = 44;
   localparam int CsrDataW = 32;
   localparam int CsrIdxW  = 3;
   localparam int NBasis   = 6;
   localparam int Lanes    = 3;
   localparam int NumW     = 51;
   localparam int DenW     = 64;
   localparam int RemW     = DenW + 1;
   localparam int QuoW     = 33;
   localparam int FracBits = 31;
   localparam int DivStg   = FracBits + 2;
   localparam int ProdW    = CoefW + BasisW;
   localparam int SumW     = ProdW + 2;

   typedef enum logic [CsrIdxW-1:0] {
      REG_LOWER_KNOT  = 3'd0,
      REG_KNOT_A      = 3'd1,
      REG_KNOT_B      = 3'd2,
      REG_KNOT_C      = 3'd3,
      REG_UPPER_KNOT  = 3'd4,
      REG_WEIGHTS_12  = 3'd5,
      REG_WEIGHTS_34  = 3'd6,
      REG_WEIGHTS_56  = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [TimeW-1:0] lower;
      logic [TimeW-1:0] knot_a;
      logic [TimeW-1:0] knot_b;
      logic [TimeW-1:0] knot_c;
      logic [TimeW-1:0] upper;
   } knots_type;

   typedef logic [NBasis-1:0][CoefW-1:0] coef_type;

   // travels beside each request: domain flag and active span (0..3)
   typedef struct packed {
      logic       dom;
      logic [1:0] span;
   } side_type;

endpackage

`default_nettype wire

### hdl/mshb_if.sv
// ----------------------------------------------------------------------------
// mshb_req_if / mshb_rsp_if
// Valid/ready channels for sample requests and basis/hazard results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mshb_req_if;
   logic                       valid;
   logic                       ready;
   logic [mshb_pkg::TimeW-1:0] sample_time;

   modport source (output valid, output sample_time, input ready);
   modport sink   (input valid, input sample_time, output ready);
endinterface

interface mshb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mshb_pkg::BasisW-1:0] basis_one;
   logic [mshb_pkg::BasisW-1:0] basis_two;
   logic [mshb_pkg::BasisW-1:0] basis_three;
   logic [mshb_pkg::BasisW-1:0] basis_four;
   logic [mshb_pkg::BasisW-1:0] basis_five;
   logic [mshb_pkg::BasisW-1:0] basis_six;
   logic [mshb_pkg::HazW-1:0]   hazard;
   logic                        in_domain;

   modport source (output valid, output basis_one, output basis_two, output basis_three,
                   output basis_four, output basis_five, output basis_six,
                   output hazard, output in_domain, input ready);
   modport sink   (input valid, input basis_one, input basis_two, input basis_three,
                   input basis_four, input basis_five, input basis_six,
                   input hazard, input in_domain, output ready);
endinterface

`default_nettype wire

### hdl/mshb_span.sv
// ----------------------------------------------------------------------------
// mshb_span
// Span search, knot differences and the numerator/denominator products of
// the three nonzero basis values. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mshb_span (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [mshb_pkg::TimeW-1:0]          in_time,
   input  wire mshb_pkg::knots_type                 knots,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [mshb_pkg::Lanes-1:0][mshb_pkg::NumW-1:0] out_num,
   output logic [mshb_pkg::Lanes-1:0][mshb_pkg::DenW-1:0] out_den,
   output mshb_pkg::side_type                       out_side
);

   localparam int TW = mshb_pkg::TimeW;
   localparam int L  = mshb_pkg::Lanes;

   function automatic logic in_span(input logic [TW-1:0] lo, input logic [TW-1:0] hi,
                                    input logic [TW-1:0] up, input logic [TW-1:0] t);
      return (hi > lo) && (t >= lo) && ((t < hi) || ((hi == up) && (t <= hi)));
   endfunction

   // stage A
   logic a_v_ff, a_ld;
   logic a_hit_in, a_hit_ff;
   mshb_pkg::side_type a_side_in, a_side_ff;
   logic [TW-1:0] a_u_in, a_u_ff, a_rgt_in, a_rgt_ff, a_tl_in, a_tl_ff, a_tr_in, a_tr_ff;
   logic [TW-1:0] a_w_in, a_w_ff, a_d2a_in, a_d2a_ff, a_d2b_in, a_d2b_ff;
   logic [L-1:0][TW-1:0] a_d3_in, a_d3_ff;
   // stage B
   logic b_v_ff, b_ld, b_hit_ff;
   mshb_pkg::side_type b_side_ff;
   logic [2*TW-1:0] b_uu_in, b_uu_ff, b_rr_in, b_rr_ff, b_rt_in, b_rt_ff;
   logic [2*TW-1:0] b_utr_in, b_utr_ff, b_wa_in, b_wa_ff;
   logic [L-1:0][2*TW-1:0] b_bd_in, b_bd_ff;
   logic [TW-1:0] b_d2a_ff, b_d2b_ff;
   // stage C
   logic c_v_ff, c_ld, c_hit_ff;
   mshb_pkg::side_type c_side_ff;
   logic [3*TW-1:0] c_p0_in, c_p0_ff, c_pa_in, c_pa_ff, c_pb_in, c_pb_ff, c_p2_in, c_p2_ff;
   logic [L-1:0][mshb_pkg::DenW-1:0] c_den_in, c_den_ff;
   // stage D
   logic d_v_ff, d_ld;
   logic [L-1:0][mshb_pkg::NumW-1:0] d_num_in, d_num_ff;
   logic [L-1:0][mshb_pkg::DenW-1:0] d_den_in, d_den_ff;
   mshb_pkg::side_type d_side_ff;

   assign d_ld     = !d_v_ff || out_ready;
   assign c_ld     = !c_v_ff || d_ld;
   assign b_ld     = !b_v_ff || c_ld;
   assign a_ld     = !a_v_ff || b_ld;
   assign in_ready = a_ld;

   always_comb begin
      logic [TW-1:0] ext [9];
      logic          ordered;
      logic [3:0]    j;
      ext[0] = knots.lower;
      ext[1] = knots.lower;
      ext[2] = knots.lower;
      ext[3] = knots.knot_a;
      ext[4] = knots.knot_b;
      ext[5] = knots.knot_c;
      ext[6] = knots.upper;
      ext[7] = knots.upper;
      ext[8] = knots.upper;
      ordered = (knots.lower <= knots.knot_a) && (knots.knot_a <= knots.knot_b) &&
                (knots.knot_b <= knots.knot_c) && (knots.knot_c <= knots.upper);
      a_side_in.dom  = ordered && (in_time >= knots.lower) && (in_time <= knots.upper);
      a_side_in.span = 2'd0;
      a_hit_in       = 1'b0;
      if (a_side_in.dom) begin
         priority if (in_span(knots.lower, knots.knot_a, knots.upper, in_time)) begin
            a_hit_in = 1'b1;
            a_side_in.span = 2'd0;
         end else if (in_span(knots.knot_a, knots.knot_b, knots.upper, in_time)) begin
            a_hit_in = 1'b1;
            a_side_in.span = 2'd1;
         end else if (in_span(knots.knot_b, knots.knot_c, knots.upper, in_time)) begin
            a_hit_in = 1'b1;
            a_side_in.span = 2'd2;
         end else if (in_span(knots.knot_c, knots.upper, knots.upper, in_time)) begin
            a_hit_in = 1'b1;
            a_side_in.span = 2'd3;
         end else begin
            a_hit_in = 1'b0;
         end
      end
      j = {2'b00, a_side_in.span} + 4'd2;
      a_u_in   = in_time - ext[j];
      a_rgt_in = ext[j + 4'd1] - in_time;
      a_tl_in  = in_time - ext[j - 4'd1];
      a_tr_in  = ext[j + 4'd2] - in_time;
      a_w_in   = ext[j + 4'd1] - ext[j];
      a_d2a_in = ext[j + 4'd1] - ext[j - 4'd1];
      a_d2b_in = ext[j + 4'd2] - ext[j];
      for (int l = 0; l < L; l++) begin
         a_d3_in[l] = ext[j + 4'd1 + 4'(l)] - ext[j - 4'd2 + 4'(l)];
      end
   end

   always_comb begin
      b_uu_in  = (2*TW)'(a_u_ff) * (2*TW)'(a_u_ff);
      b_rr_in  = (2*TW)'(a_rgt_ff) * (2*TW)'(a_rgt_ff);
      b_rt_in  = (2*TW)'(a_rgt_ff) * (2*TW)'(a_tl_ff);
      b_utr_in = (2*TW)'(a_u_ff) * (2*TW)'(a_tr_ff);
      b_wa_in  = (2*TW)'(a_w_ff) * (2*TW)'(a_d2a_ff);
      for (int l = 0; l < L; l++) begin
         b_bd_in[l] = (2*TW)'(a_d2b_ff) * (2*TW)'(a_d3_ff[l]);
      end
      c_p0_in = (3*TW)'(b_rr_ff) * (3*TW)'(b_d2b_ff);
      c_pa_in = (3*TW)'(b_rt_ff) * (3*TW)'(b_d2b_ff);
      c_pb_in = (3*TW)'(b_utr_ff) * (3*TW)'(b_d2a_ff);
      c_p2_in = (3*TW)'(b_uu_ff) * (3*TW)'(b_d2a_ff);
      for (int l = 0; l < L; l++) begin
         c_den_in[l] = mshb_pkg::DenW'(b_wa_ff) * mshb_pkg::DenW'(b_bd_ff[l]);
      end
   end

   always_comb begin
      logic [3*TW:0] mid;
      mid = {1'b0, c_pa_ff} + {1'b0, c_pb_ff};
      d_num_in[0] = {3'b000, c_p0_ff} + {2'b00, c_p0_ff, 1'b0};
      d_num_in[1] = {2'b00, mid} + {1'b0, mid, 1'b0};
      d_num_in[2] = {3'b000, c_p2_ff} + {2'b00, c_p2_ff, 1'b0};
      for (int l = 0; l < L; l++) begin
         d_den_in[l] = c_hit_ff ? c_den_ff[l] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (a_ld) a_v_ff <= in_valid;
         if (b_ld) b_v_ff <= a_v_ff;
         if (c_ld) c_v_ff <= b_v_ff;
         if (d_ld) d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ld) begin
         a_hit_ff  <= a_hit_in;
         a_side_ff <= a_side_in;
         a_u_ff    <= a_u_in;
         a_rgt_ff  <= a_rgt_in;
         a_tl_ff   <= a_tl_in;
         a_tr_ff   <= a_tr_in;
         a_w_ff    <= a_w_in;
         a_d2a_ff  <= a_d2a_in;
         a_d2b_ff  <= a_d2b_in;
         a_d3_ff   <= a_d3_in;
      end
      if (b_ld) begin
         b_hit_ff  <= a_hit_ff;
         b_side_ff <= a_side_ff;
         b_uu_ff   <= b_uu_in;
         b_rr_ff   <= b_rr_in;
         b_rt_ff   <= b_rt_in;
         b_utr_ff  <= b_utr_in;
         b_wa_ff   <= b_wa_in;
         b_bd_ff   <= b_bd_in;
         b_d2a_ff  <= a_d2a_ff;
         b_d2b_ff  <= a_d2b_ff;
      end
      if (c_ld) begin
         c_hit_ff  <= b_hit_ff;
         c_side_ff <= b_side_ff;
         c_p0_ff   <= c_p0_in;
         c_pa_ff   <= c_pa_in;
         c_pb_ff   <= c_pb_in;
         c_p2_ff   <= c_p2_in;
         c_den_ff  <= c_den_in;
      end
      if (d_ld) begin
         d_side_ff <= c_side_ff;
         d_num_ff  <= d_num_in;
         d_den_ff  <= d_den_in;
      end
   end

   assign out_valid = d_v_ff;
   assign out_num   = d_num_ff;
   assign out_den   = d_den_ff;
   assign out_side  = d_side_ff;

endmodule

`default_nettype wire

### hdl/mshb_div.sv
// ----------------------------------------------------------------------------
// mshb_div
// Three-lane restoring divider, one quotient bit per stage, giving the
// basis values in Q2.30 rounded to nearest (ties up) with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mshb_div (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        in_valid,
   output logic                                             in_ready,
   input  wire logic [mshb_pkg::Lanes-1:0][mshb_pkg::NumW-1:0] in_num,
   input  wire logic [mshb_pkg::Lanes-1:0][mshb_pkg::DenW-1:0] in_den,
   input  wire mshb_pkg::side_type                          in_side,
   output logic                                             out_valid,
   input  wire logic                                        out_ready,
   output logic [mshb_pkg::Lanes-1:0][mshb_pkg::BasisW-1:0] out_basis,
   output mshb_pkg::side_type                               out_side
);

   localparam int L  = mshb_pkg::Lanes;
   localparam int NS = mshb_pkg::DivStg;
   localparam int RW = mshb_pkg::RemW;
   localparam int DW = mshb_pkg::DenW;
   localparam int QW = mshb_pkg::QuoW;

   logic [NS:0] v_ff, ld;

   logic [RW-1:0] r_in   [NS][L];
   logic [RW-1:0] r_ff   [NS][L];
   logic [DW-1:0] den_ff [NS][L];
   logic [QW-1:0] q_in   [NS][L];
   logic [QW-1:0] q_ff   [NS][L];
   logic          sat_in [L];
   logic          sat_ff [NS][L];
   logic          zero_ff[NS][L];
   mshb_pkg::side_type side_ff [NS];

   logic [L-1:0][mshb_pkg::BasisW-1:0] basis_in, basis_ff;
   mshb_pkg::side_type                 oside_ff;

   always_comb begin
      for (int st = NS; st >= 0; st--) begin
         if (st == NS) ld[st] = !v_ff[st] || out_ready;
         else          ld[st] = !v_ff[st] || ld[st+1];
      end
   end
   assign in_ready = ld[0];

   always_comb begin
      logic [RW:0]   num_x;
      logic          ge;
      logic [RW-1:0] trial;
      for (int l = 0; l < L; l++) begin
         // integer bit 1, with the overflow check for values of four or more
         num_x      = (RW+1)'(in_num[l]);
         sat_in[l]  = num_x >= {in_den[l], 2'b00};
         ge         = num_x[RW-1:0] >= {in_den[l], 1'b0};
         r_in[0][l] = ge ? (num_x[RW-1:0] - {in_den[l], 1'b0}) : num_x[RW-1:0];
         q_in[0][l] = {{(QW-1){1'b0}}, ge};
      end
      for (int st = 1; st < NS; st++) begin
         for (int l = 0; l < L; l++) begin
            if (st == 1) trial = r_ff[0][l];
            else         trial = {r_ff[st-1][l][RW-2:0], 1'b0};
            ge          = trial >= {1'b0, den_ff[st-1][l]};
            r_in[st][l] = ge ? (trial - {1'b0, den_ff[st-1][l]}) : trial;
            q_in[st][l] = {q_ff[st-1][l][QW-2:0], ge};
         end
      end
   end

   always_comb begin
      logic [QW:0] rnd;
      for (int l = 0; l < L; l++) begin
         rnd = {1'b0, q_ff[NS-1][l]} + (QW+1)'(1);
         priority if (zero_ff[NS-1][l]) begin
            basis_in[l] = '0;
         end else if (sat_ff[NS-1][l] || rnd[QW]) begin
            basis_in[l] = '1;
         end else begin
            basis_in[l] = rnd[QW-1:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int st = 0; st <= NS; st++) begin
            if (ld[st]) v_ff[st] <= (st == 0) ? in_valid : v_ff[st-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         side_ff[0] <= in_side;
         for (int l = 0; l < L; l++) begin
            r_ff[0][l]    <= r_in[0][l];
            q_ff[0][l]    <= q_in[0][l];
            den_ff[0][l]  <= in_den[l];
            sat_ff[0][l]  <= sat_in[l];
            zero_ff[0][l] <= in_den[l] == '0;
         end
      end
      for (int st = 1; st < NS; st++) begin
         if (ld[st]) begin
            side_ff[st] <= side_ff[st-1];
            for (int l = 0; l < L; l++) begin
               r_ff[st][l]    <= r_in[st][l];
               q_ff[st][l]    <= q_in[st][l];
               den_ff[st][l]  <= den_ff[st-1][l];
               sat_ff[st][l]  <= sat_ff[st-1][l];
               zero_ff[st][l] <= zero_ff[st-1][l];
            end
         end
      end
      if (ld[NS]) begin
         basis_ff <= basis_in;
         oside_ff <= side_ff[NS-1];
      end
   end

   assign out_valid = v_ff[NS];
   assign out_basis = basis_ff;
   assign out_side  = oside_ff;

endmodule

`default_nettype wire

### hdl/mshb_haz.sv
// ----------------------------------------------------------------------------
// mshb_haz
// Places the three lane values on their basis slots and forms the
// coefficient-weighted hazard. Two register stages, the last is the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mshb_haz (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         in_valid,
   output logic                                              in_ready,
   input  wire logic [mshb_pkg::Lanes-1:0][mshb_pkg::BasisW-1:0] in_basis,
   input  wire mshb_pkg::side_type                           in_side,
   input  wire mshb_pkg::coef_type                           coef,
   output logic                                              out_valid,
   input  wire logic                                         out_ready,
   output logic [mshb_pkg::NBasis-1:0][mshb_pkg::BasisW-1:0] out_basis,
   output logic [mshb_pkg::HazW-1:0]                         out_hazard,
   output logic                                              out_dom
);

   localparam int L  = mshb_pkg::Lanes;
   localparam int NB = mshb_pkg::NBasis;
   localparam int PW = mshb_pkg::ProdW;
   localparam int SW = mshb_pkg::SumW;

   logic e_v_ff, e_ld, f_v_ff, f_ld;
   logic [NB-1:0][mshb_pkg::BasisW-1:0] e_basis_in, e_basis_ff, f_basis_ff;
   logic [L-1:0][PW-1:0]                e_prod_in, e_prod_ff;
   logic                                e_dom_ff, f_dom_ff;
   logic [mshb_pkg::HazW-1:0]           f_haz_in, f_haz_ff;

   assign f_ld     = !f_v_ff || out_ready;
   assign e_ld     = !e_v_ff || f_ld;
   assign in_ready = e_ld;

   always_comb begin
      logic [2:0] m;
      e_basis_in = '0;
      for (int l = 0; l < L; l++) begin
         m = {1'b0, in_side.span} + 3'(l);
         e_basis_in[m] = in_basis[l];
         e_prod_in[l]  = PW'(coef[m]) * PW'(in_basis[l]);
      end
   end

   always_comb begin
      logic [SW-1:0] sum;
      sum = SW'(e_prod_ff[0]) + SW'(e_prod_ff[1]) + SW'(e_prod_ff[2]) + SW'(128);
      // Q10.38 to Q14.30; three products cannot reach the 44-bit ceiling
      f_haz_in = mshb_pkg::HazW'(sum[SW-1:8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         if (e_ld) e_v_ff <= in_valid;
         if (f_ld) f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ld) begin
         e_basis_ff <= e_basis_in;
         e_prod_ff  <= e_prod_in;
         e_dom_ff   <= in_side.dom;
      end
      if (f_ld) begin
         f_basis_ff <= e_basis_ff;
         f_haz_ff   <= f_haz_in;
         f_dom_ff   <= e_dom_ff;
      end
   end

   assign out_valid  = f_v_ff;
   assign out_basis  = f_basis_ff;
   assign out_hazard = f_haz_ff;
   assign out_dom    = f_dom_ff;

endmodule

`default_nettype wire

### hdl/mspline_hazard_basis_core.sv
// ----------------------------------------------------------------------------
// mspline_hazard_basis_core
// Quadratic M-spline basis over a clamped knot vector, and the weighted
// hazard, for one time sample per request.
// ----------------------------------------------------------------------------
//  port      direction  content
//  req_ch    in         sample_time (16 b)
//  rsp_ch    out        basis_one..basis_six (Q2.30), hazard (Q14.30), in_domain
//  csr_*     in         knot and weight registers, write only
//
//  One request per cycle when the result side is not stalling; 4 span/product
//  stages, 33 divider stages (one quotient bit each) plus rounding, 2 hazard stages.
//  Reset clears the stage valid bits and loads the register defaults.
//  Every stage holds when full and blocked, so bubbles close up under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mspline_hazard_basis_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mshb_req_if.sink                              req_ch,
   mshb_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_wr_en,
   input  wire logic [mshb_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [mshb_pkg::CsrDataW-1:0]    csr_wdata
);

   localparam int L = mshb_pkg::Lanes;

   mshb_pkg::knots_type knots_ff;
   logic [mshb_pkg::CsrDataW-1:0] w12_ff, w34_ff, w56_ff;
   mshb_pkg::coef_type coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         knots_ff.lower  <= 16'd0;
         knots_ff.knot_a <= 16'd16384;
         knots_ff.knot_b <= 16'd32768;
         knots_ff.knot_c <= 16'd49152;
         knots_ff.upper  <= 16'd65535;
         w12_ff          <= 32'h0100_0100;
         w34_ff          <= 32'h0100_0100;
         w56_ff          <= 32'h0100_0100;
      end else if (csr_wr_en) begin
         unique case (mshb_pkg::csr_reg_type'(csr_index))
            mshb_pkg::REG_LOWER_KNOT: knots_ff.lower  <= csr_wdata[mshb_pkg::TimeW-1:0];
            mshb_pkg::REG_KNOT_A:     knots_ff.knot_a <= csr_wdata[mshb_pkg::TimeW-1:0];
            mshb_pkg::REG_KNOT_B:     knots_ff.knot_b <= csr_wdata[mshb_pkg::TimeW-1:0];
            mshb_pkg::REG_KNOT_C:     knots_ff.knot_c <= csr_wdata[mshb_pkg::TimeW-1:0];
            mshb_pkg::REG_UPPER_KNOT: knots_ff.upper  <= csr_wdata[mshb_pkg::TimeW-1:0];
            mshb_pkg::REG_WEIGHTS_12: w12_ff <= csr_wdata;
            mshb_pkg::REG_WEIGHTS_34: w34_ff <= csr_wdata;
            mshb_pkg::REG_WEIGHTS_56: w56_ff <= csr_wdata;
         endcase
      end
   end

   assign coef[0] = w12_ff[15:0];
   assign coef[1] = w12_ff[31:16];
   assign coef[2] = w34_ff[15:0];
   assign coef[3] = w34_ff[31:16];
   assign coef[4] = w56_ff[15:0];
   assign coef[5] = w56_ff[31:16];

   logic sp_valid, sp_ready, dv_valid, dv_ready;
   logic [L-1:0][mshb_pkg::NumW-1:0]   sp_num;
   logic [L-1:0][mshb_pkg::DenW-1:0]   sp_den;
   logic [L-1:0][mshb_pkg::BasisW-1:0] dv_basis;
   mshb_pkg::side_type sp_side, dv_side;
   logic [mshb_pkg::NBasis-1:0][mshb_pkg::BasisW-1:0] basis;

   mshb_span u_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_time   (req_ch.sample_time),
      .knots     (knots_ff),
      .out_valid (sp_valid),
      .out_ready (sp_ready),
      .out_num   (sp_num),
      .out_den   (sp_den),
      .out_side  (sp_side)
   );

   mshb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sp_valid),
      .in_ready  (sp_ready),
      .in_num    (sp_num),
      .in_den    (sp_den),
      .in_side   (sp_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_basis (dv_basis),
      .out_side  (dv_side)
   );

   mshb_haz u_haz (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid),
      .in_ready   (dv_ready),
      .in_basis   (dv_basis),
      .in_side    (dv_side),
      .coef       (coef),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_basis  (basis),
      .out_hazard (rsp_ch.hazard),
      .out_dom    (rsp_ch.in_domain)
   );

   assign rsp_ch.basis_one   = basis[0];
   assign rsp_ch.basis_two   = basis[1];
   assign rsp_ch.basis_three = basis[2];
   assign rsp_ch.basis_four  = basis[3];
   assign rsp_ch.basis_five  = basis[4];
   assign rsp_ch.basis_six   = basis[5];

endmodule

`default_nettype wire

### hdl/mshb_chk.sv
// ----------------------------------------------------------------------------
// mshb_chk
// Port-level checks on the result channel of the hazard basis core.
// ----------------------------------------------------------------------------
`default_nettype none

module mshb_chk (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [mshb_pkg::BasisW-1:0]       b1,
   input wire logic [mshb_pkg::BasisW-1:0]       b2,
   input wire logic [mshb_pkg::BasisW-1:0]       b3,
   input wire logic [mshb_pkg::BasisW-1:0]       b4,
   input wire logic [mshb_pkg::BasisW-1:0]       b5,
   input wire logic [mshb_pkg::BasisW-1:0]       b6,
   input wire logic [mshb_pkg::HazW-1:0]         hazard,
   input wire logic                              in_domain
);

   logic [5:0] nz;
   assign nz = {b6 != '0, b5 != '0, b4 != '0, b3 != '0, b2 != '0, b1 != '0};

   // no result straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // outside the domain everything is zero
   a_out_of_domain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_domain |-> nz == 6'd0 && hazard == '0)
      else $error("nonzero result outside domain");

   // a quadratic spline has at most three live basis functions
   a_support: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(nz) <= 3)
      else $error("more than three nonzero basis values");

   // a stalled result stays valid and keeps its hazard and first basis value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hazard) && $stable(b1))
      else $error("stalled result changed");

endmodule

bind mspline_hazard_basis_core mshb_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .b1        (rsp_ch.basis_one),
   .b2        (rsp_ch.basis_two),
   .b3        (rsp_ch.basis_three),
   .b4        (rsp_ch.basis_four),
   .b5        (rsp_ch.basis_five),
   .b6        (rsp_ch.basis_six),
   .hazard    (rsp_ch.hazard),
   .in_domain (rsp_ch.in_domain)
);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadratic M-spline hazard basis core. Time
// samples are pushed through the request channel under a number of knot and
// weight settings. Each accepted request is scored against a bit-accurate
// model of the closed-form quadratic basis and the rounded, saturated hazard. Both
// channel sides stall at random, and one long result hold-off backs the
// pipeline up into the request side.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [mshb_pkg::BasisW-1:0] basis [mshb_pkg::NBasis];
      logic [mshb_pkg::HazW-1:0]   hazard;
      logic                        in_domain;
   } basis_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [mshb_pkg::CsrIdxW-1:0]  csr_index;
   logic [mshb_pkg::CsrDataW-1:0] csr_wdata;

   mshb_req_if req_ch ();
   mshb_rsp_if rsp_ch ();

   mspline_hazard_basis_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow
   logic [mshb_pkg::TimeW-1:0] knot_sh [5];
   logic [mshb_pkg::CoefW-1:0] coef_sh [mshb_pkg::NBasis];

   basis_result_type pending_results [$];
   int  n_sent, n_checked, n_errors, n_phases;
   bit  idle_on;
   bit  hold_req;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [mshb_pkg::BasisW-1:0] round_q230(longint unsigned num,
                                                             longint unsigned den);
      longint unsigned q, r, v, qbit;
      if (den == 0)
         return '0;
      q = num / den;
      r = num % den;
      if (q > 3)
         return '1;
      v = q;
      for (int b = 0; b < 31; b++) begin
         if (r >= den - r) begin
            r = r - (den - r);
            qbit = 1;
         end else begin
            r = r << 1;
            qbit = 0;
         end
         v = (v << 1) | qbit;
      end
      v = (v + 1) >> 1;
      return (v > 64'hFFFF_FFFF) ? '1 : v[mshb_pkg::BasisW-1:0];
   endfunction

   function automatic basis_result_type predict_basis(logic [mshb_pkg::TimeW-1:0] t_in);
      basis_result_type res;
      longint unsigned ext [9];
      longint unsigned t, w, d2a, d2b, u, rgt, common, p, d3, hz, lo, hi;
      bit ordered;
      int j;
      t = t_in;
      for (int i = 0; i < 3; i++) begin
         ext[i]     = knot_sh[0];
         ext[i + 6] = knot_sh[4];
      end
      for (int i = 0; i < 3; i++)
         ext[i + 3] = knot_sh[i + 1];
      ordered = 1;
      for (int i = 0; i < 8; i++)
         if (ext[i] > ext[i + 1])
            ordered = 0;
      res.in_domain = ordered && t >= ext[0] && t <= ext[8];
      for (int i = 0; i < mshb_pkg::NBasis; i++)
         res.basis[i] = '0;
      j = -1;
      if (res.in_domain) begin
         for (int i = 0; i < 8 && j < 0; i++) begin
            lo = ext[i];
            hi = ext[i + 1];
            if (hi > lo && t >= lo && (t < hi || (hi == ext[8] && t <= hi)))
               j = i;
         end
      end
      if (j >= 2 && j + 2 < 9 && j < mshb_pkg::NBasis) begin
         w      = ext[j + 1] - ext[j];
         d2a    = ext[j + 1] - ext[j - 1];
         d2b    = ext[j + 2] - ext[j];
         u      = t - ext[j];
         rgt    = ext[j + 1] - t;
         common = w * d2a * d2b;
         for (int k = j - 2; k <= j; k++) begin
            d3 = ext[k + 3] - ext[k];
            if (k == j)
               p = u * u * d2a;
            else if (k == j - 1)
               p = rgt * (t - ext[j - 1]) * d2b + u * (ext[j + 2] - t) * d2a;
            else
               p = rgt * rgt * d2b;
            res.basis[k] = round_q230(3 * p, common * d3);
         end
      end
      hz = 0;
      for (int i = 0; i < mshb_pkg::NBasis; i++)
         hz += longint'(coef_sh[i]) * longint'(res.basis[i]);
      hz = (hz + 128) >> 8;
      res.hazard = (hz > 64'h0FFF_FFFF_FFFF) ? '1 : hz[mshb_pkg::HazW-1:0];
      return res;
   endfunction

   task automatic write_reg(mshb_pkg::csr_reg_type idx,
                            logic [mshb_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         mshb_pkg::REG_WEIGHTS_12: begin
            coef_sh[0] = value[15:0]; coef_sh[1] = value[31:16];
         end
         mshb_pkg::REG_WEIGHTS_34: begin
            coef_sh[2] = value[15:0]; coef_sh[3] = value[31:16];
         end
         mshb_pkg::REG_WEIGHTS_56: begin
            coef_sh[4] = value[15:0]; coef_sh[5] = value[31:16];
         end
         default: knot_sh[idx] = value[mshb_pkg::TimeW-1:0];
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic drain_pipe();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_knots(logic [mshb_pkg::TimeW-1:0] lo, logic [mshb_pkg::TimeW-1:0] a,
                            logic [mshb_pkg::TimeW-1:0] b, logic [mshb_pkg::TimeW-1:0] c,
                            logic [mshb_pkg::TimeW-1:0] hi);
      drain_pipe();
      write_reg(mshb_pkg::REG_LOWER_KNOT, lo);
      write_reg(mshb_pkg::REG_KNOT_A, a);
      write_reg(mshb_pkg::REG_KNOT_B, b);
      write_reg(mshb_pkg::REG_KNOT_C, c);
      write_reg(mshb_pkg::REG_UPPER_KNOT, hi);
      n_phases++;
   endtask

   task automatic set_weights(logic [31:0] w12, logic [31:0] w34, logic [31:0] w56);
      drain_pipe();
      write_reg(mshb_pkg::REG_WEIGHTS_12, w12);
      write_reg(mshb_pkg::REG_WEIGHTS_34, w34);
      write_reg(mshb_pkg::REG_WEIGHTS_56, w56);
   endtask

   // valid is left high after acceptance; the next call moves the payload on
   task automatic send_sample(logic [mshb_pkg::TimeW-1:0] t);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.sample_time = t;
      do
         @(posedge clock);
      while (!req_ch.ready);
      pending_results.push_back(predict_basis(t));
      n_sent++;
   endtask

   task automatic test_reset_defaults();
      logic [mshb_pkg::TimeW-1:0] pts [] = '{16'd0, 16'd1, 16'd16383, 16'd16384,
                                              16'd16385, 16'd32768, 16'd49151,
                                              16'd49152, 16'd65534, 16'd65535};
      foreach (pts[i])
         send_sample(pts[i]);
   endtask

   task automatic test_outside_domain();
      set_knots(16'd100, 16'd200, 16'd3000, 16'd40000, 16'd60000);
      set_weights(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(16'd0);
      send_sample(16'd99);
      send_sample(16'd100);
      send_sample(16'd60000);
      send_sample(16'd60001);
      send_sample(16'hFFFF);
   endtask

   task automatic test_misordered_knots();
      set_knots(16'd10, 16'd500, 16'd400, 16'd800, 16'd1000);
      send_sample(16'd450);
      send_sample(16'd10);
   endtask

   task automatic test_equal_bounds();
      set_knots(16'd500, 16'd500, 16'd500, 16'd500, 16'd500);
      send_sample(16'd499);
      send_sample(16'd500);
      send_sample(16'd501);
   endtask

   task automatic test_repeated_interior();
      set_weights(32'h0000_0000, 32'h8000_0001, 32'h0100_FFFF);
      set_knots(16'd0, 16'd0, 16'd7, 16'd7, 16'd9);
      send_sample(16'd0);
      send_sample(16'd7);
      send_sample(16'd8);
      send_sample(16'd9);
   endtask

   function automatic logic [mshb_pkg::TimeW-1:0] pick_time();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return $urandom_range(0, 16'hFFFF);
      if (sel == 1)
         return knot_sh[$urandom_range(0, 4)];
      if (knot_sh[0] <= knot_sh[4])
         return $urandom_range(knot_sh[4], knot_sh[0]);
      return $urandom_range(0, 16'hFFFF);
   endfunction

   task automatic random_settings();
      logic [mshb_pkg::TimeW-1:0] k [5];
      logic [mshb_pkg::TimeW-1:0] tmp;
      int sel, span;
      sel = $urandom_range(0, 9);
      span = ($urandom_range(0, 2) == 0) ? 16'hFFFF : $urandom_range(1, 40);
      k[0] = $urandom_range(0, 16'hFFFF - span);
      for (int i = 1; i < 5; i++)
         k[i] = k[0] + $urandom_range(0, span);
      if (sel != 0) begin
         for (int i = 0; i < 5; i++)
            for (int m = 0; m < 4 - i; m++)
               if (k[m] > k[m + 1]) begin
                  tmp = k[m]; k[m] = k[m + 1]; k[m + 1] = tmp;
               end
      end
      if (sel == 1) begin
         k[2] = k[1];
         k[3] = k[1];
      end
      if (sel == 2) begin
         k[0] = 16'd0;
         k[4] = 16'hFFFF;
      end
      set_knots(k[0], k[1], k[2], k[3], k[4]);
      if ($urandom_range(0, 4) == 0)
         set_weights('1, '1, '1);
      else
         set_weights($urandom, $urandom, $urandom);
   endtask

   task automatic test_random_sweep(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         random_settings();
         repeat (per_phase) send_sample(pick_time());
      end
   endtask

   task automatic test_backpressure();
      random_settings();
      hold_req = 1'b1;
      repeat (80) send_sample(pick_time());
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      random_settings();
      repeat (200) send_sample(pick_time());
   endtask

   // response side ready pattern
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ch.ready = 1'b0;
            repeat (150) @(negedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                  exp_v, act_v);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      basis_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual hazard %0h",
                     $realtime, rsp_ch.hazard);
            n_errors++;
         end else begin
            exp_r = pending_results.pop_front();
            check_field("basis_one",   exp_r.basis[0], rsp_ch.basis_one);
            check_field("basis_two",   exp_r.basis[1], rsp_ch.basis_two);
            check_field("basis_three", exp_r.basis[2], rsp_ch.basis_three);
            check_field("basis_four",  exp_r.basis[3], rsp_ch.basis_four);
            check_field("basis_five",  exp_r.basis[4], rsp_ch.basis_five);
            check_field("basis_six",   exp_r.basis[5], rsp_ch.basis_six);
            check_field("hazard",      exp_r.hazard,   rsp_ch.hazard);
            check_field("in_domain",   exp_r.in_domain, rsp_ch.in_domain);
            n_checked++;
         end
      end
   end

   initial begin
      #(12 * 3000000);
      $display("tb_top failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = mshb_pkg::REG_LOWER_KNOT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.sample_time = '0;
      idle_on = 1'b1;
      hold_req = 1'b0;
      knot_sh = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
      foreach (coef_sh[i])
         coef_sh[i] = 16'h0100;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_outside_domain();
      test_misordered_knots();
      test_equal_bounds();
      test_repeated_interior();
      test_random_sweep(24, 60);
      test_backpressure();
      test_full_rate();

      drain_pipe();
      $display("%0d requests checked over %0d knot settings, %0d results compared",
               n_sent, n_phases, n_checked);
      if (n_errors == 0 && pending_results.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule

### filelist.f
hdl/mshb_pkg.sv
hdl/mshb_if.sv
hdl/mshb_span.sv
hdl/mshb_div.sv
hdl/mshb_haz.sv
hdl/mspline_hazard_basis_core.sv
hdl/mshb_chk.sv
sim/tb_top.sv
